FILE: design/block_median_sorter_unit_assert.svh
// Assertion macros used by the block's checker file.
`ifndef BLOCK_MEDIAN_SORTER_UNIT_ASSERT_SVH
`define BLOCK_MEDIAN_SORTER_UNIT_ASSERT_SVH

// Clocked check that is switched off while reset is high.
`define BMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BMS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/bms_pkg.sv
package bms_pkg;

  // Capacity of the sorting chain and the field widths.
  localparam int MAX_SAMPLES = 64;
  localparam int SAMPLE_W    = 32;
  localparam int COUNT_OUT_W = 7;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

  // Commands broadcast from the controller to every cell.
  typedef struct packed {
    logic ins;  // insert the broadcast sample
    logic shl;  // shift the chain one cell toward the head
    logic clr;  // mark every cell empty
  } cell_ctrl_t;

endpackage

FILE: design/bms_cell.sv
module bms_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bms_pkg::cell_ctrl_t                  ctrl,
  input  logic signed [bms_pkg::SAMPLE_W-1:0]  sample,
  input  logic signed [bms_pkg::SAMPLE_W-1:0]  prev_val,
  input  logic                                 prev_gt,
  input  logic                                 prev_occ,
  input  logic signed [bms_pkg::SAMPLE_W-1:0]  next_val,
  input  logic                                 next_occ,
  output logic signed [bms_pkg::SAMPLE_W-1:0]  val,
  output logic                                 gt,
  output logic                                 occ
);

  // This cell's value sorts after the incoming sample.
  assign gt = occ && (val > sample);

  // Occupancy follows the chain: inserts grow it at the tail.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.clr) begin
      occ <= 1'b0;
    end else if (ctrl.shl) begin
      occ <= next_occ;
    end else if (ctrl.ins) begin
      occ <= occ | prev_occ;
    end
  end

  // Insertion moves larger values one cell toward the tail; the sample lands
  // in the first cell that is larger than it, or in the first empty cell.
  always_ff @(posedge clk) begin
    if (ctrl.shl) begin
      val <= next_val;
    end else if (ctrl.ins) begin
      if (prev_gt) begin
        val <= prev_val;
      end else if (gt || (!occ && prev_occ)) begin
        val <= sample;
      end
    end
  end

endmodule

FILE: design/bms_ctrl.sv
module bms_ctrl (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 last,
  input  logic signed [bms_pkg::SAMPLE_W-1:0]  head_val,
  input  logic signed [bms_pkg::SAMPLE_W-1:0]  second_val,
  output bms_pkg::cell_ctrl_t                  ctrl,
  output logic                                 busy,
  output logic                                 strobe,
  output logic signed [bms_pkg::SAMPLE_W-1:0]  median_value,
  output logic [bms_pkg::COUNT_OUT_W-1:0]      sample_count,
  output logic                                 overflowed
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic                          state;
  logic [bms_pkg::CNT_W-1:0]     fill;
  logic [bms_pkg::CNT_W-1:0]     fill_next;
  logic [bms_pkg::CNT_W-1:0]     shift_cnt;
  logic                          overflow;
  logic                          overflow_next;
  logic                          even;
  logic                          accept;
  logic                          full;
  logic                          drain_done;
  logic signed [bms_pkg::SAMPLE_W:0] pair_sum;

  assign busy       = (state == S_DRAIN);
  assign accept     = start && !busy;
  assign full       = (fill == bms_pkg::CNT_W'(bms_pkg::MAX_SAMPLES));
  assign drain_done = busy && (shift_cnt == '0);

  // Count after this transaction; a sample that finds the chain full is dropped.
  assign fill_next     = full ? fill : fill + bms_pkg::CNT_W'(1);
  assign overflow_next = overflow | full;

  // Cell commands.
  assign ctrl.ins = accept && !full;
  assign ctrl.shl = busy && (shift_cnt != '0);
  assign ctrl.clr = drain_done;

  // Mean of the two middle cells, rounded toward minus infinity.
  assign pair_sum = {head_val[bms_pkg::SAMPLE_W-1], head_val}
                  + {second_val[bms_pkg::SAMPLE_W-1], second_val};

  // Block bookkeeping and the drain toward the median.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      overflow  <= 1'b0;
      shift_cnt <= '0;
    end else if (busy) begin
      if (drain_done) begin
        state    <= S_IDLE;
        fill     <= '0;
        overflow <= 1'b0;
      end else begin
        shift_cnt <= shift_cnt - bms_pkg::CNT_W'(1);
      end
    end else if (accept) begin
      fill     <= fill_next;
      overflow <= overflow_next;
      if (last) begin
        state     <= S_DRAIN;
        shift_cnt <= (fill_next - bms_pkg::CNT_W'(1)) >> 1;
      end
    end
  end

  // Parity of the kept count picks one middle cell or the pair.
  always_ff @(posedge clk) begin
    if (accept && last) begin
      even <= !fill_next[0];
    end
  end

  // Result strobe lasts one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= drain_done;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (drain_done) begin
      median_value <= even ? pair_sum[bms_pkg::SAMPLE_W:1] : head_val;
      sample_count <= bms_pkg::COUNT_OUT_W'(fill);
      overflowed   <= overflow;
    end
  end

endmodule

FILE: design/block_median_sorter_unit.sv
// Accepts one sample per cycle, while busy is low, into a 64-cell insertion-sort chain.
// After the transaction marked last, the chain shifts toward its head until the
// middle of the N kept samples reaches the head cell; the result is then registered
// and shown with strobe, and busy is high meanwhile.
// The receiver cannot stall. Synchronous rst empties the chain and idles the block.
module block_median_sorter_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [bms_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                 last,
  output logic                                 strobe,
  output logic signed [bms_pkg::SAMPLE_W-1:0]  median_value,
  output logic [bms_pkg::COUNT_OUT_W-1:0]      sample_count,
  output logic                                 overflowed
);

  bms_pkg::cell_ctrl_t                  ctrl;
  logic signed [bms_pkg::SAMPLE_W-1:0]  cell_val [bms_pkg::MAX_SAMPLES];
  logic                                 cell_gt  [bms_pkg::MAX_SAMPLES];
  logic                                 cell_occ [bms_pkg::MAX_SAMPLES];

  // Sequencing, counts and median arithmetic.
  bms_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .last         (last),
    .head_val     (cell_val[0]),
    .second_val   (cell_val[1]),
    .ctrl         (ctrl),
    .busy         (busy),
    .strobe       (strobe),
    .median_value (median_value),
    .sample_count (sample_count),
    .overflowed   (overflowed)
  );

  // Row of sorting cells; each sees its two neighbors.
  for (genvar i = 0; i < bms_pkg::MAX_SAMPLES; i++) begin : g_cell
    logic signed [bms_pkg::SAMPLE_W-1:0] prev_val;
    logic                                prev_gt;
    logic                                prev_occ;
    logic signed [bms_pkg::SAMPLE_W-1:0] next_val;
    logic                                next_occ;

    if (i == 0) begin : g_head
      assign prev_val = '0;
      assign prev_gt  = 1'b0;
      assign prev_occ = 1'b1;
    end else begin : g_body
      assign prev_val = cell_val[i-1];
      assign prev_gt  = cell_gt[i-1];
      assign prev_occ = cell_occ[i-1];
    end

    if (i == bms_pkg::MAX_SAMPLES - 1) begin : g_tail
      assign next_val = '0;
      assign next_occ = 1'b0;
    end else begin : g_link
      assign next_val = cell_val[i+1];
      assign next_occ = cell_occ[i+1];
    end

    bms_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .sample   (sample),
      .prev_val (prev_val),
      .prev_gt  (prev_gt),
      .prev_occ (prev_occ),
      .next_val (next_val),
      .next_occ (next_occ),
      .val      (cell_val[i]),
      .gt       (cell_gt[i]),
      .occ      (cell_occ[i])
    );
  end

endmodule

FILE: design/bms_checker.sv
`include "block_median_sorter_unit_assert.svh"

module bms_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 start,
  input logic                                 busy,
  input logic signed [bms_pkg::SAMPLE_W-1:0]  sample,
  input logic                                 last,
  input logic                                 strobe,
  input logic signed [bms_pkg::SAMPLE_W-1:0]  median_value,
  input logic [bms_pkg::COUNT_OUT_W-1:0]      sample_count,
  input logic                                 overflowed
);

  // A block's last transaction always starts the drain.
  `BMS_ASSERT(a_last_busy, start && !busy && last |=> busy, "last sample did not start drain")

  // The drain ends only by presenting a result.
  `BMS_ASSERT(a_drain_result, !$past(rst) && $fell(busy) |-> strobe, "drain ended without result")

  // Results are single-cycle and never back to back.
  `BMS_ASSERT(a_strobe_single, strobe |=> !strobe, "result strobe held two cycles")

  // A reported block is never empty, and dropping implies a full chain.
  `BMS_ASSERT(a_count_valid,
    strobe |-> (sample_count != '0) &&
      (!overflowed ||
       sample_count == bms_pkg::COUNT_OUT_W'(bms_pkg::MAX_SAMPLES)),
    "bad sample count in result")

endmodule

bind block_median_sorter_unit bms_checker u_bms_checker (.*);
